// ----- rtl/assert_macros.svh -----
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop, msg)

`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

// ----- rtl/rpcp_pkg.sv -----
`default_nettype none

package rpcp_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ID_W      = 8;
    localparam int RND_W     = 16;
    localparam int STEP_W    = $clog2(RND_W);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [ID_W-1:0]  item_id;
        logic [RND_W-1:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  picked_id;
        logic             picked_valid;
        logic             add_accepted;
        logic [CNT_W-1:0] available_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_RD_SEL,
        ST_RD_LAST,
        ST_SWAP,
        ST_RETURN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/rpcp_mod_unit.sv -----
`default_nettype none

module rpcp_mod_unit
    import rpcp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RND_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [IDX_W-1:0]      remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  shifted;

    // shift in one dividend bit, subtract when it fits
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[RND_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = (shifted >= dsr_reg) ? IDX_W'(shifted - dsr_reg)
                                             : shifted[IDX_W-1:0];
            dvd_next  = {dvd_reg[RND_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(RND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/random_pick_with_cooldown_pool.sv -----
// Random pick pool with cooldown.
// Input channel in_valid/in_ready carries in_item: opcode add or pick, the id
// to add and a 16-bit random value. Output channel out_valid/out_ready
// carries exactly one out_item per input item, in order.
// An add stores its id if the pool has room, then loads the result. A pick
// on a non-empty pool first runs the bit-serial remainder unit (16 steps),
// then reads, swap, return write and result load on the id stores, each
// with one read and one write port. A pick on an empty pool goes straight
// to the result load. One item is in work at a time and the sequencer
// returns to idle before the next accept.
// in_ready is high when the sequencer is idle; the next item is taken while
// the previous result still waits in the output register.
// If the receiver stalls with a result pending and another result is ready,
// the sequencer holds in its final step until the output register frees.
// Reset clears all counters and ring pointers; the id stores need no
// clearing since no entry's value is used before it is written.
`default_nettype none

`include "assert_macros.svh"

module random_pick_with_cooldown_pool
    import rpcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] avail_reg, avail_next;
    logic [CNT_W-1:0] cool_reg, cool_next;
    logic [CNT_W-1:0] pool_reg, pool_next;
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [IDX_W-1:0] ri_reg, ri_next;

    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  picked_reg;
    logic             valid_reg;
    logic             acc_reg;
    logic [IDX_W-1:0] sel_reg;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg;

    logic [ID_W-1:0]  store_mem [POOL_SIZE];
    logic [ID_W-1:0]  ring_mem  [POOL_SIZE];
    logic [ID_W-1:0]  store_rdata_reg;
    logic [ID_W-1:0]  ring_rdata_reg;

    logic             store_we;
    logic [IDX_W-1:0] store_waddr;
    logic [ID_W-1:0]  store_wdata;
    logic [IDX_W-1:0] store_raddr;
    logic             ring_we;

    logic             accept;
    logic             div_start;
    logic             div_done;
    logic [IDX_W-1:0] div_rem;
    logic             load_out;
    logic [IDX_W-1:0] last_idx;
    logic             do_return;
    logic [ID_W-1:0]  return_id;
    logic             room;

    assign accept    = in_valid && in_ready;
    assign last_idx  = IDX_W'(avail_reg - 1'b1);
    assign room      = pool_reg < CNT_W'(POOL_SIZE);
    assign do_return = ((9'(cool_reg) + 9'd1) * 9'd5 >= 9'(pool_reg) * 9'd3)
                       || (avail_reg == CNT_W'(1));
    assign return_id = (cool_reg == '0) ? picked_reg : ring_rdata_reg;

    rpcp_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_item.random_value),
        .divisor   (avail_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.opcode == OP_ADD)
                        state_next = ST_ADD;
                    else if (avail_reg != '0)
                        state_next = ST_DIV;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_ADD:     state_next = ST_DONE;
            ST_DIV:     state_next = div_done ? ST_RD_SEL : ST_DIV;
            ST_RD_SEL:  state_next = ST_RD_LAST;
            ST_RD_LAST: state_next = ST_SWAP;
            ST_SWAP:    state_next = ST_RETURN;
            ST_RETURN:  state_next = ST_DONE;
            ST_DONE:    state_next = load_out ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        store_we    = 1'b0;
        store_waddr = last_idx;
        store_wdata = return_id;
        store_raddr = sel_reg;
        ring_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_valid && (in_item.opcode == OP_PICK) && (avail_reg != '0);
            end
            ST_ADD:
            begin
                store_we    = room;
                store_waddr = avail_reg[IDX_W-1:0];
                store_wdata = id_reg;
            end
            ST_RD_LAST:
            begin
                store_raddr = last_idx;
            end
            ST_SWAP:
            begin
                store_we    = sel_reg != last_idx;
                store_waddr = sel_reg;
                store_wdata = store_rdata_reg;
                ring_we     = 1'b1;
            end
            ST_RETURN:
            begin
                store_we = do_return;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        avail_next = avail_reg;
        cool_next  = cool_reg;
        pool_next  = pool_reg;
        wi_next    = wi_reg;
        ri_next    = ri_reg;
        if (state_reg == ST_ADD && room)
        begin
            avail_next = avail_reg + 1'b1;
            pool_next  = pool_reg + 1'b1;
        end
        else if (state_reg == ST_RETURN)
        begin
            wi_next = wi_reg + 1'b1;
            if (do_return)
            begin
                ri_next = ri_reg + 1'b1;
            end
            else
            begin
                avail_next = avail_reg - 1'b1;
                cool_next  = cool_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avail_reg     <= '0;
            cool_reg      <= '0;
            pool_reg      <= '0;
            wi_reg        <= '0;
            ri_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            avail_reg     <= avail_next;
            cool_reg      <= cool_next;
            pool_reg      <= pool_next;
            wi_reg        <= wi_next;
            ri_reg        <= ri_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold item fields and build the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg     <= in_item.item_id;
            picked_reg <= '0;
            valid_reg  <= 1'b0;
            acc_reg    <= 1'b0;
        end
        if (state_reg == ST_ADD)
            acc_reg <= room;
        if (state_reg == ST_DIV && div_done)
            sel_reg <= div_rem;
        if (state_reg == ST_RD_LAST)
        begin
            picked_reg <= store_rdata_reg;
            valid_reg  <= 1'b1;
        end
        if (load_out)
        begin
            out_item_reg.picked_id       <= picked_reg;
            out_item_reg.picked_valid    <= valid_reg;
            out_item_reg.add_accepted    <= acc_reg;
            out_item_reg.available_count <= avail_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= store_wdata;
        store_rdata_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wi_reg] <= picked_reg;
        ring_rdata_reg <= ring_mem[ri_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_ALWAYS(a_count_sum, clk, rst_n,
        (8'(avail_reg) + 8'(cool_reg)) == 8'(pool_reg), "available plus cooling differs from total")
    `ASSERT_ALWAYS(a_pool_bound, clk, rst_n,
        pool_reg <= CNT_W'(POOL_SIZE), "pool total exceeds pool size")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n,
        accept, state_reg != ST_IDLE, "sequencer idle right after accepting an item")
    `ASSERT_NEXT(a_done_hold, clk, rst_n,
        state_reg == ST_DONE && out_valid_reg && !out_ready,
        state_reg == ST_DONE, "result dropped while output register was occupied")

endmodule

`default_nettype wire

// ----- bench/tb_random_pick_with_cooldown_pool.sv -----
`default_nettype none

module tb_random_pick_with_cooldown_pool;
    import rpcp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    random_pick_with_cooldown_pool u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    logic [ID_W-1:0] pool_ids [POOL_SIZE];
    logic [ID_W-1:0] cooldown_ids [POOL_SIZE];
    int avail_n   = 0;
    int cooling_n = 0;
    int pool_n    = 0;
    int ring_wr   = 0;
    int ring_rd   = 0;

    out_item_t expected_results [$];
    int error_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int ready_mode  = 0;
    int mode_left   = 0;

    always #4 clk = ~clk;

    function automatic void return_to_pool(input logic [ID_W-1:0] id);
        if (avail_n < POOL_SIZE)
        begin
            pool_ids[avail_n] = id;
            avail_n++;
        end
    endfunction

    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t r;
        int        sel;
        r = '0;
        if (it.opcode == OP_ADD)
        begin
            if (pool_n < POOL_SIZE)
            begin
                return_to_pool(it.item_id);
                pool_n++;
                r.add_accepted = 1'b1;
            end
        end
        else if (avail_n != 0)
        begin
            sel = int'(it.random_value) % avail_n;
            r.picked_id = pool_ids[sel];
            avail_n--;
            if (sel != avail_n)
                pool_ids[sel] = pool_ids[avail_n];
            cooldown_ids[ring_wr] = r.picked_id;
            ring_wr = (ring_wr + 1) % POOL_SIZE;
            cooling_n++;
            if (cooling_n * 5 >= pool_n * 3 || avail_n == 0)
            begin
                cooling_n--;
                return_to_pool(cooldown_ids[ring_rd]);
                ring_rd = (ring_rd + 1) % POOL_SIZE;
            end
            r.picked_valid = 1'b1;
        end
        r.available_count = CNT_W'(avail_n);
        return r;
    endfunction

    function automatic logic [RND_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return RND_W'($urandom_range(0, 127));
            default: return RND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                             input logic [RND_W-1:0] rnd);
        in_item_t it;
        it.opcode       = op;
        it.item_id      = id;
        it.random_value = rnd;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_result(it));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_empty_pick();
        send_item(OP_PICK, 8'h00, 16'h0000);
        send_item(OP_PICK, 8'hFF, 16'hFFFF);
        send_item(OP_PICK, 8'h5A, 16'h8000);
        wait_for_results();
    endtask

    task automatic test_field_extremes();
        send_item(OP_ADD,  8'h00, 16'hFFFF);
        send_item(OP_PICK, 8'hFF, 16'hFFFF);
        send_item(OP_PICK, 8'h00, 16'h0000);
        send_item(OP_ADD,  8'hFF, 16'h0000);
        send_item(OP_ADD,  8'hAA, 16'h5555);
        send_item(OP_ADD,  8'h55, 16'hAAAA);
        send_item(OP_PICK, 8'h00, 16'hFFFF);
        send_item(OP_PICK, 8'h00, 16'h0000);
        send_item(OP_PICK, 8'hFF, 16'h8000);
        send_item(OP_PICK, 8'h00, 16'h0001);
        send_item(OP_ADD,  8'h01, 16'h7FFF);
        send_item(OP_PICK, 8'h80, 16'h7FFF);
        wait_for_results();
    endtask

    task automatic test_random_growth();
        while (pool_n < POOL_SIZE)
        begin
            if ($urandom_range(0, 99) < 30)
                send_item(OP_ADD, ID_W'($urandom_range(0, 255)), random_word());
            else
                send_item(OP_PICK, ID_W'($urandom_range(0, 255)), random_word());
        end
        wait_for_results();
    endtask

    task automatic test_full_pool();
        while (pool_n < POOL_SIZE)
            send_item(OP_ADD, ID_W'($urandom_range(0, 255)), random_word());
        send_item(OP_ADD,  8'h00, 16'h0000);
        send_item(OP_ADD,  8'hFF, 16'hFFFF);
        send_item(OP_PICK, 8'h00, 16'hFFFF);
        send_item(OP_PICK, 8'hFF, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_random_full();
        repeat (400)
        begin
            if ($urandom_range(0, 99) < 15)
                send_item(OP_ADD, ID_W'($urandom_range(0, 255)), random_word());
            else
                send_item(OP_PICK, ID_W'($urandom_range(0, 255)), random_word());
        end
        wait_for_results();
    endtask

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        else
            mode_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 15) == 0) ? ~out_ready : out_ready;
        endcase
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected item", 32'(out_item), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (out_item.picked_id !== want.picked_id)
                    report_mismatch("picked_id", 32'(out_item.picked_id),
                                    32'(want.picked_id));
                if (out_item.picked_valid !== want.picked_valid)
                    report_mismatch("picked_valid", 32'(out_item.picked_valid),
                                    32'(want.picked_valid));
                if (out_item.add_accepted !== want.add_accepted)
                    report_mismatch("add_accepted", 32'(out_item.add_accepted),
                                    32'(want.add_accepted));
                if (out_item.available_count !== want.available_count)
                    report_mismatch("available_count", 32'(out_item.available_count),
                                    32'(want.available_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("random_pick_with_cooldown_pool test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pick();
        test_field_extremes();
        test_random_growth();
        test_full_pool();
        test_random_full();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("items never returned", 32'(expected_results.size()), 32'd0);
        if (error_count == 0)
            $display("random_pick_with_cooldown_pool test passed");
        else
            $display("random_pick_with_cooldown_pool test failed");
        $finish;
    end

endmodule

`default_nettype wire
